// ----- hdl/lcd4_pkg.sv -----
// Shared types and constants for the 4-bit character LCD sequencer.
// Holds request codes, queue entry layout and the power-up step table.
// No dependencies.
package lcd4_pkg;

	localparam int unsigned WAIT_W    = 9;
	localparam int unsigned WAIT_MAX  = 511;
	localparam int unsigned STEP_W    = 4;
	localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd14;

	typedef enum logic [2:0] {
		OP_COMMAND = 3'd0,
		OP_DATA    = 3'd1,
		OP_GOTO    = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_HOME    = 3'd4,
		OP_INIT    = 3'd5
	} opcode_t;

	// which wait a step ends with
	typedef enum logic [2:0] {
		WS_NONE  = 3'd0,
		WS_ONE   = 3'd1,
		WS_CLEAR = 3'd2,
		WS_1MS   = 3'd3,
		WS_5MS   = 3'd4,
		WS_15MS  = 3'd5
	} wait_sel_t;

	// one request as the back end sees it
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] data;
		logic       long_wait;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} qhead_t;

	typedef struct packed {
		logic      strobe;
		logic [3:0] nibble;
		wait_sel_t wsel;
	} init_step_t;

	// power-up sequence: long wait, 3 x 0x3, 0x2, then 28 08 01 06 0C
	function automatic init_step_t init_step(input logic [STEP_W-1:0] idx);
		init_step_t s;
		case (idx)
			4'd0:    s = '{1'b0, 4'h0, WS_15MS};
			4'd1:    s = '{1'b1, 4'h3, WS_5MS};
			4'd2:    s = '{1'b1, 4'h3, WS_5MS};
			4'd3:    s = '{1'b1, 4'h3, WS_5MS};
			4'd4:    s = '{1'b1, 4'h2, WS_1MS};
			4'd5:    s = '{1'b1, 4'h2, WS_NONE};
			4'd6:    s = '{1'b1, 4'h8, WS_ONE};
			4'd7:    s = '{1'b1, 4'h0, WS_NONE};
			4'd8:    s = '{1'b1, 4'h8, WS_ONE};
			4'd9:    s = '{1'b1, 4'h0, WS_NONE};
			4'd10:   s = '{1'b1, 4'h1, WS_CLEAR};
			4'd11:   s = '{1'b1, 4'h0, WS_NONE};
			4'd12:   s = '{1'b1, 4'h6, WS_ONE};
			4'd13:   s = '{1'b1, 4'h0, WS_NONE};
			4'd14:   s = '{1'b1, 4'hC, WS_ONE};
			default: s = '{1'b0, 4'h0, WS_NONE};
		endcase
		return s;
	endfunction

endpackage

// ----- hdl/lcd4_if.sv -----
// Valid/ready channel interfaces for requests and bus steps.
// Depends on nothing.
interface lcd4_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] value;
	logic [5:0] column;
	logic       row;

	modport source (output valid, output opcode, output value, output column,
		output row, input ready);
	modport sink (input valid, input opcode, input value, input column,
		input row, output ready);
endinterface

interface lcd4_step_if;
	logic       valid;
	logic       ready;
	logic       strobe_res;
	logic       reg_select;
	logic [3:0] nibble;
	logic [8:0] wait_ticks;
	logic       backlight;
	logic       last;

	modport source (output valid, output strobe_res, output reg_select,
		output nibble, output wait_ticks, output backlight, output last,
		input ready);
	modport sink (input valid, input strobe_res, input reg_select,
		input nibble, input wait_ticks, input backlight, input last,
		output ready);
endinterface

// ----- hdl/lcd4_front.sv -----
// Front end: takes requests, decodes them into queue entries.
// Uses lcd4_pkg and lcd4_req_if.
module lcd4_front (
	lcd4_req_if.sink req,
	input  logic            full,
	output logic            push,
	output lcd4_pkg::entry_t entry
);
	logic       known;
	logic [6:0] ddram_addr;

	assign ddram_addr = {1'b0, req.column} + {req.row, 6'b0};

	always_comb begin
		known = 1'b1;
		entry = '{is_init: 1'b0, rs: 1'b0, data: req.value, long_wait: 1'b0};
		case (req.opcode)
			lcd4_pkg::OP_COMMAND: entry.data = req.value;
			lcd4_pkg::OP_DATA:    entry.rs = 1'b1;
			lcd4_pkg::OP_GOTO:    entry.data = {1'b1, ddram_addr};
			lcd4_pkg::OP_CLEAR: begin
				entry.data      = 8'h01;
				entry.long_wait = 1'b1;
			end
			lcd4_pkg::OP_HOME: begin
				entry.data      = 8'h02;
				entry.long_wait = 1'b1;
			end
			lcd4_pkg::OP_INIT:    entry.is_init = 1'b1;
			default:              known = 1'b0;
		endcase
	end

	// unknown opcodes are taken and dropped
	assign req.ready = !full;
	assign push      = req.valid && !full && known;
endmodule

// ----- hdl/lcd4_queue.sv -----
// Two-entry queue between the request decoder and the step sequencer.
// Uses lcd4_pkg.
module lcd4_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lcd4_pkg::entry_t push_entry,
	input  logic             pop,
	output logic             full,
	output lcd4_pkg::qhead_t head
);
	lcd4_pkg::entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full       = count_q[1];
	assign head.valid = count_q != 2'd0;
	assign head.entry = mem_q[rd_ptr_q];
endmodule

// ----- hdl/lcd4_back.sv -----
// Back end: walks the steps of the request at the queue head into an
// output register. Uses lcd4_pkg and lcd4_step_if.
module lcd4_back #(
	parameter int unsigned TICKS_PER_MS = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lcd4_pkg::qhead_t head,
	output logic             pop,
	lcd4_step_if.source      step
);
	localparam int unsigned T = TICKS_PER_MS;
	localparam logic [lcd4_pkg::WAIT_W-1:0] W_ONE =
		lcd4_pkg::WAIT_W'(1);
	localparam logic [lcd4_pkg::WAIT_W-1:0] W_CLEAR =
		lcd4_pkg::WAIT_W'((1 + 2 * T > lcd4_pkg::WAIT_MAX) ? lcd4_pkg::WAIT_MAX : 1 + 2 * T);
	localparam logic [lcd4_pkg::WAIT_W-1:0] W_1MS =
		lcd4_pkg::WAIT_W'((T > lcd4_pkg::WAIT_MAX) ? lcd4_pkg::WAIT_MAX : T);
	localparam logic [lcd4_pkg::WAIT_W-1:0] W_5MS =
		lcd4_pkg::WAIT_W'((5 * T > lcd4_pkg::WAIT_MAX) ? lcd4_pkg::WAIT_MAX : 5 * T);
	localparam logic [lcd4_pkg::WAIT_W-1:0] W_15MS =
		lcd4_pkg::WAIT_W'((15 * T > lcd4_pkg::WAIT_MAX) ? lcd4_pkg::WAIT_MAX : 15 * T);

	logic [lcd4_pkg::STEP_W-1:0] step_q;
	logic backlight_q;
	logic valid_q;

	lcd4_pkg::init_step_t  ist;
	lcd4_pkg::wait_sel_t   wsel;
	logic                  n_strobe;
	logic                  n_rs;
	logic [3:0]            n_nibble;
	logic                  n_last;
	logic [lcd4_pkg::WAIT_W-1:0] n_wait;
	logic                  load;

	always_comb begin
		ist = lcd4_pkg::init_step(step_q);
		if (head.entry.is_init) begin
			n_strobe = ist.strobe;
			n_rs     = 1'b0;
			n_nibble = ist.nibble;
			wsel     = ist.wsel;
			n_last   = step_q == lcd4_pkg::INIT_LAST_STEP;
		end else begin
			// high nibble first with no wait, then the low nibble
			n_strobe = 1'b1;
			n_rs     = head.entry.rs;
			n_nibble = step_q[0] ? head.entry.data[3:0] : head.entry.data[7:4];
			if (!step_q[0])
				wsel = lcd4_pkg::WS_NONE;
			else if (head.entry.long_wait)
				wsel = lcd4_pkg::WS_CLEAR;
			else
				wsel = lcd4_pkg::WS_ONE;
			n_last = step_q[0];
		end
	end

	always_comb begin
		case (wsel)
			lcd4_pkg::WS_NONE:  n_wait = '0;
			lcd4_pkg::WS_ONE:   n_wait = W_ONE;
			lcd4_pkg::WS_CLEAR: n_wait = W_CLEAR;
			lcd4_pkg::WS_1MS:   n_wait = W_1MS;
			lcd4_pkg::WS_5MS:   n_wait = W_5MS;
			lcd4_pkg::WS_15MS:  n_wait = W_15MS;
			default:            n_wait = '0;
		endcase
	end

	assign load = head.valid && (!valid_q || step.ready);
	assign pop  = load && n_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			backlight_q <= 1'b0;
			valid_q     <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= n_last ? '0 : step_q + 1'b1;
				// backlight goes on after the opening wait of power-up
				if (head.entry.is_init)
					backlight_q <= 1'b1;
			end else if (step.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			step.strobe_res <= n_strobe;
			step.reg_select <= n_rs;
			step.nibble     <= n_nibble;
			step.wait_ticks <= n_wait;
			step.backlight  <= backlight_q;
			step.last       <= n_last;
		end
	end

	assign step.valid = valid_q;
endmodule

// ----- hdl/char_lcd_4bit_sequencer.sv -----
// Top level of the 4-bit character LCD sequencer.
// Depends on lcd4_pkg, lcd4_if, lcd4_front, lcd4_queue and lcd4_back.
//
//  channel | dir | fields
//  req     | in  | opcode, value, column, row
//  step    | out | strobe_res, reg_select, nibble, wait_ticks, backlight, last
//
// One bus step leaves per cycle while step.ready is high and a request waits;
// lcd4_back sends a byte high nibble first and walks the power-up step table.
// Up to two decoded requests wait in the queue; req.ready drops when it is full.
// A stall on step holds the output register and the step counter.
// Reset clears the queue, the sequencer and the backlight level.
module char_lcd_4bit_sequencer #(
	parameter int unsigned TICKS_PER_MS = 20
) (
	input logic          clk,
	input logic          arst_n,
	lcd4_req_if.sink     req,
	lcd4_step_if.source  step
);
	logic             full;
	logic             push;
	logic             pop;
	lcd4_pkg::entry_t entry;
	lcd4_pkg::qhead_t head;

	lcd4_front u_front (
		.req   (req),
		.full  (full),
		.push  (push),
		.entry (entry)
	);

	lcd4_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (entry),
		.pop        (pop),
		.full       (full),
		.head       (head)
	);

	lcd4_back #(
		.TICKS_PER_MS (TICKS_PER_MS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.step   (step)
	);
endmodule

// ----- hdl/lcd4_checker.sv -----
// Port-level checks for the LCD sequencer, bound to the top level.
// Depends on char_lcd_4bit_sequencer.
module lcd4_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       step_valid,
	input logic       step_ready,
	input logic       strobe_res,
	input logic       reg_select,
	input logic [3:0] nibble,
	input logic [8:0] wait_ticks,
	input logic       last
);
	// a stalled transfer holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && !step_ready |=> step_valid && $stable(nibble)
		&& $stable(wait_ticks) && $stable(last))
		else $error("step payload changed under stall");

	// a wait-only step drives nothing on the bus
	a_wait_only: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && !strobe_res |-> !reg_select && nibble == 4'h0 && !last)
		else $error("wait-only step with bus activity");

	// zero wait only after a high nibble, which never ends a request
	a_zero_wait: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && wait_ticks == 9'd0 |-> strobe_res && !last)
		else $error("zero wait on final or wait-only step");

	// the final step of a request always waits
	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && last |-> wait_ticks != 9'd0 && strobe_res)
		else $error("final step without wait");
endmodule

bind char_lcd_4bit_sequencer lcd4_checker u_lcd4_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.step_valid (step.valid),
	.step_ready (step.ready),
	.strobe_res (step.strobe_res),
	.reg_select (step.reg_select),
	.nibble     (step.nibble),
	.wait_ticks (step.wait_ticks),
	.last       (step.last)
);

// ----- tb/char_lcd_4bit_sequencer_test.sv -----
// Self-checking testbench for char_lcd_4bit_sequencer: directed and random requests,
// with each bus step checked against an in-bench expansion of the request.
// Depends on lcd4_pkg, lcd4_if and the sequencer RTL.
module char_lcd_4bit_sequencer_test;

	localparam int unsigned TICKS_PER_MS   = 20;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned ITEMS_PER_PHASE = 30;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		logic                        strobe;
		logic                        rs;
		logic [3:0]                  nibble;
		logic [lcd4_pkg::WAIT_W-1:0] wait_ticks;
		logic                        backlight;
		logic                        last;
	} lcd_step_t;

	// expands requests into bus steps and checks them in order
	class lcd_step_scoreboard;
		lcd_step_t pending_steps[$];
		bit        backlight_on;
		int        errors;

		function new();
			backlight_on = 1'b0;
			errors = 0;
		endfunction

		function void add_step(bit strobe, bit rs, logic [3:0] nib, int unsigned ticks);
			lcd_step_t s;
			s.strobe = strobe;
			s.rs = rs;
			s.nibble = nib;
			s.wait_ticks = (ticks > lcd4_pkg::WAIT_MAX) ?
				lcd4_pkg::WAIT_W'(lcd4_pkg::WAIT_MAX) : lcd4_pkg::WAIT_W'(ticks);
			s.backlight = backlight_on;
			s.last = 1'b0;
			pending_steps.push_back(s);
		endfunction

		// high nibble with no wait, then low nibble with one tick plus any extra
		function void add_byte(bit rs, logic [7:0] b, int unsigned extra);
			add_step(1'b1, rs, b[7:4], 0);
			add_step(1'b1, rs, b[3:0], 1 + extra);
		endfunction

		function void note_request(logic [2:0] op, logic [7:0] val, logic [5:0] col,
			logic row);
			logic [7:0] addr;
			addr = 8'h80 | ({2'b00, col} + (row ? 8'h40 : 8'h00));
			case (op)
				lcd4_pkg::OP_COMMAND: add_byte(1'b0, val, 0);
				lcd4_pkg::OP_DATA:    add_byte(1'b1, val, 0);
				lcd4_pkg::OP_GOTO:    add_byte(1'b0, addr, 0);
				lcd4_pkg::OP_CLEAR:   add_byte(1'b0, 8'h01, 2 * TICKS_PER_MS);
				lcd4_pkg::OP_HOME:    add_byte(1'b0, 8'h02, 2 * TICKS_PER_MS);
				lcd4_pkg::OP_INIT: begin
					// power-on wait still shows the old backlight level
					add_step(1'b0, 1'b0, 4'h0, 15 * TICKS_PER_MS);
					backlight_on = 1'b1;
					repeat (3) add_step(1'b1, 1'b0, 4'h3, 5 * TICKS_PER_MS);
					add_step(1'b1, 1'b0, 4'h2, TICKS_PER_MS);
					add_byte(1'b0, 8'h28, 0);
					add_byte(1'b0, 8'h08, 0);
					add_byte(1'b0, 8'h01, 2 * TICKS_PER_MS);
					add_byte(1'b0, 8'h06, 0);
					add_byte(1'b0, 8'h0C, 0);
				end
				default: return;
			endcase
			pending_steps[pending_steps.size() - 1].last = 1'b1;
		endfunction

		function string fmt_step(lcd_step_t s);
			return $sformatf("strobe=%0d rs=%0d nibble=%h wait=%0d backlight=%0d last=%0d",
				s.strobe, s.rs, s.nibble, s.wait_ticks, s.backlight, s.last);
		endfunction

		function void check_step(lcd_step_t got);
			lcd_step_t exp;
			if (pending_steps.size() == 0) begin
				errors++;
				$display("%0t: unexpected step: %s", $time, fmt_step(got));
				return;
			end
			exp = pending_steps.pop_front();
			if (got !== exp) begin
				errors++;
				$display("%0t: step mismatch: expected %s, actual %s", $time,
					fmt_step(exp), fmt_step(got));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   quiet_cycles;

	lcd4_req_if  req();
	lcd4_step_if step();

	lcd_step_scoreboard sb = new();

	char_lcd_4bit_sequencer #(
		.TICKS_PER_MS(TICKS_PER_MS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.step  (step)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		step.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// sampled mid-cycle: the values here are the ones transferred at the next edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request(req.opcode, req.value, req.column, req.row);
			if (step.valid && step.ready)
				sb.check_step('{step.strobe_res, step.reg_select, step.nibble,
					step.wait_ticks, step.backlight, step.last});
			if ((req.valid && req.ready) || (step.valid && step.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("[char_lcd_4bit_sequencer] ERROR");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [2:0] op, input logic [7:0] val,
		input logic [5:0] col, input logic row);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid  <= 1'b1;
		req.opcode <= op;
		req.value  <= val;
		req.column <= col;
		req.row    <= row;
		forever begin
			@(negedge clk);
			if (req.ready)
				break;
		end
		@(posedge clk);
	endtask

	// hold the request side until every step owed has come out
	task automatic wait_for_drain();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_steps.size() != 0);
	endtask

	task automatic send_random_request(output bit counted);
		int pick;
		logic [2:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			op = lcd4_pkg::OP_COMMAND;
		else if (pick < 55)
			op = lcd4_pkg::OP_DATA;
		else if (pick < 80)
			op = lcd4_pkg::OP_GOTO;
		else if (pick < 87)
			op = lcd4_pkg::OP_CLEAR;
		else if (pick < 94)
			op = lcd4_pkg::OP_HOME;
		else if (pick < 97)
			op = lcd4_pkg::OP_INIT;
		else
			op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
		counted = (op != OP_SPARE_6) && (op != OP_SPARE_7);
		send_request(op, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)));
		if ($urandom_range(0, 29) == 0)
			wait_for_drain();
	endtask

	initial begin
		int sent;
		bit counted;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = lcd4_pkg::OP_COMMAND;
		req.value = 8'h00;
		req.column = 6'd0;
		req.row = 1'b0;
		step.ready = 1'b0;
		quiet_cycles = 0;
		src_idle_pct = 21;
		sink_idle_pct = 68;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before power-up the backlight is still off
		send_request(lcd4_pkg::OP_COMMAND, 8'h00, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_DATA, 8'hFF, 6'd63, 1'b1);
		send_request(OP_SPARE_6, 8'hFF, 6'd63, 1'b1);
		send_request(OP_SPARE_7, 8'h00, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_GOTO, 8'h00, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_CLEAR, 8'h00, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_HOME, 8'h00, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_INIT, 8'h00, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_COMMAND, 8'hFF, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_DATA, 8'h00, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_DATA, 8'h5A, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_DATA, 8'hA5, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_GOTO, 8'h00, 6'd63, 1'b1);
		send_request(lcd4_pkg::OP_GOTO, 8'h00, 6'd63, 1'b0);
		send_request(lcd4_pkg::OP_GOTO, 8'h00, 6'd0, 1'b1);
		send_request(lcd4_pkg::OP_GOTO, 8'h00, 6'd21, 1'b1);
		send_request(lcd4_pkg::OP_GOTO, 8'h00, 6'd42, 1'b0);
		send_request(lcd4_pkg::OP_COMMAND, 8'h3C, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_INIT, 8'h00, 6'd0, 1'b0);
		send_request(lcd4_pkg::OP_CLEAR, 8'hFF, 6'd63, 1'b1);
		send_request(lcd4_pkg::OP_HOME, 8'hFF, 6'd63, 1'b1);
		wait_for_drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 21;
					sink_idle_pct = 68;
				end
				1: begin
					src_idle_pct = 68;
					sink_idle_pct = 21;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				send_random_request(counted);
				if (counted)
					sent++;
			end
			wait_for_drain();
		end

		// let any stray steps show up before the verdict
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending_steps.size() == 0)
			$display("[char_lcd_4bit_sequencer] OK");
		else
			$display("[char_lcd_4bit_sequencer] ERROR");
		$finish;
	end

endmodule
